[design/hbpa_pkg.sv]
// ----------------------------------------------------------------------------
// hbpa_pkg
// Shared types, constants and bitmap helper functions of the page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package hbpa_pkg;

    localparam int WORD_BITS  = 64;
    localparam int BIT_W      = 6;
    localparam int PAGE_W     = 16;
    localparam int CNT_W      = 17;
    localparam int PAGE_WORDS = 1024;
    localparam int PW_W       = 10;
    localparam int MID_WORDS  = 16;
    localparam int MW_W       = 4;
    localparam int ITEMS1_W   = 11;
    localparam int ITEMS2_W   = 5;

    localparam logic [CNT_W-1:0]    MAX_PAGES    = CNT_W'(65536);
    localparam logic [ITEMS1_W-1:0] MAX_ITEMS1   = ITEMS1_W'(PAGE_WORDS);
    localparam logic [ITEMS2_W-1:0] MAX_ITEMS2   = ITEMS2_W'(MID_WORDS);
    localparam logic [WORD_BITS-1:0] WORD_ONES   = '1;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_TOP,
        S_MID,
        S_PAGE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic            clear;
        logic [MW_W-1:0] mid_idx;
        logic            mid_en;
        logic            mid_set;
        logic [BIT_W-1:0] mid_bit;
        logic            top_en;
        logic            top_set;
    } t_sum_cmd;

    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] r;
        r = BIT_W'(WORD_BITS - 1);
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!v[i]) begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

    // bits of word w that stand at or beyond n items
    function automatic logic [WORD_BITS-1:0] pad_mask(input logic [CNT_W-1:0] n,
                                                      input logic [PW_W-1:0]  w);
        logic [CNT_W-BIT_W-1:0] n_hi;
        logic [BIT_W-1:0]       n_lo;
        logic [CNT_W-BIT_W-1:0] w_x;
        logic [WORD_BITS-1:0]   r;
        n_hi = n[CNT_W-1:BIT_W];
        n_lo = n[BIT_W-1:0];
        w_x  = (CNT_W-BIT_W)'(w);
        if (w_x < n_hi) begin
            r = '0;
        end else if (w_x == n_hi) begin
            r = ~((WORD_BITS'(1) << n_lo) - WORD_BITS'(1));
        end else begin
            r = '1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/hbpa_if.sv]
// ----------------------------------------------------------------------------
// hbpa_if
// Valid/ready channels carrying request and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface hbpa_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] page_index;

    modport source (output valid, output action, output page_index, input ready);
    modport sink   (input valid, input action, input page_index, output ready);
endinterface

interface hbpa_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] page_index_res;
    logic [1:0]  status;

    modport source (output valid, output page_index_res, output status, input ready);
    modport sink   (input valid, input page_index_res, input status, output ready);
endinterface

`default_nettype wire

[design/hierarchical_bitmap_page_allocator.sv]
// ----------------------------------------------------------------------------
// hierarchical_bitmap_page_allocator
// Three-level bitmap page allocator over 65536 pages of 64-bit words.
// ----------------------------------------------------------------------------
// One request at a time. An allocate walks the top summary word, then the
// middle summary word, then the page word; a free checks its range and goes
// straight to the page word. An allocate that finds the top word full, or a
// free out of range, goes straight to its result, and an allocate that finds
// a middle word full skips the page word. The next request is taken once the
// result is in the output register. The output register holds the result while
// the sink stalls. The walk reads the top and middle summary words from flops,
// then the page word from a 1024 x 64 synchronous RAM. It writes the page word
// back in the cycle that its read data arrives. After reset, and after every
// write of the page total, the block sweeps the page RAM to zero, all 1024
// words, and accepts no request. A page total above 65536 saturates to 65536.
// ----------------------------------------------------------------------------
`default_nettype none

module hierarchical_bitmap_page_allocator
    import hbpa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CNT_W-1:0] i_cfg_wdata,
    hbpa_req_if.sink              i_req,
    hbpa_res_if.source            o_res
);

    t_state                r_state, n_state;
    t_action               r_action, n_action;
    logic [PAGE_W-1:0]     r_index, n_index;
    logic [MW_W-1:0]       r_top, n_top;
    logic [BIT_W-1:0]      r_mid_bit, n_mid_bit;
    logic [PW_W-1:0]       r_clr_addr, n_clr_addr;
    logic [CNT_W-1:0]      r_num_pages, n_num_pages;
    logic [ITEMS1_W-1:0]   r_items1, n_items1;
    logic [ITEMS2_W-1:0]   r_items2, n_items2;
    logic [PAGE_W-1:0]     r_pend_idx, n_pend_idx;
    t_status               r_pend_status, n_pend_status;
    logic                  r_out_valid, n_out_valid;
    logic [PAGE_W-1:0]     r_out_idx, n_out_idx;
    t_status               r_out_status, n_out_status;

    t_sum_cmd              sum_cmd;
    logic [WORD_BITS-1:0]  mid_word;
    logic [MID_WORDS-1:0]  top_word;

    logic                  ram_we;
    logic [PW_W-1:0]       ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic                  ram_re;
    logic [PW_W-1:0]       ram_raddr;
    logic [WORD_BITS-1:0]  ram_rdata;

    logic [CNT_W-1:0]      cfg_sat;
    logic [CNT_W:0]        items1_sum;
    logic [ITEMS1_W:0]     items2_sum;
    logic [CNT_W-1:0]      items1_x;
    logic [CNT_W-1:0]      items2_x;
    logic [WORD_BITS-1:0]  eff_top;
    logic [WORD_BITS-1:0]  eff_mid;
    logic [WORD_BITS-1:0]  eff_page;
    logic [WORD_BITS-1:0]  pad_mid;
    logic [BIT_W-1:0]      top_bit;
    logic [PW_W-1:0]       page_word;
    logic [BIT_W-1:0]      page_bit;
    logic [WORD_BITS-1:0]  page_new;
    logic [WORD_BITS-1:0]  mid_new;
    logic                  accept;

    hbpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (PAGE_WORDS)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    hbpa_summary u_summary (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (sum_cmd),
        .o_mid_word (mid_word),
        .o_top_word (top_word)
    );

    assign i_req.ready          = (r_state == S_IDLE);
    assign accept               = i_req.valid && (r_state == S_IDLE);
    assign o_res.valid          = r_out_valid;
    assign o_res.page_index_res = r_out_idx;
    assign o_res.status         = r_out_status;

    assign cfg_sat    = (i_cfg_wdata > MAX_PAGES) ? MAX_PAGES : i_cfg_wdata;
    assign items1_sum = {1'b0, cfg_sat} + (CNT_W+1)'(WORD_BITS - 1);
    assign items2_sum = {1'b0, items1_sum[CNT_W-1:BIT_W]} + (ITEMS1_W+1)'(WORD_BITS - 1);
    assign items1_x   = CNT_W'(r_items1);
    assign items2_x   = CNT_W'(r_items2);

    assign page_word = (r_action == ACT_FREE) ? r_index[PAGE_W-1:BIT_W] : {r_top, r_mid_bit};
    assign eff_top   = {{(WORD_BITS-MID_WORDS){1'b1}}, top_word} | pad_mask(items2_x, '0);
    assign top_bit   = lowest_zero(eff_top);
    assign pad_mid   = pad_mask(items1_x, PW_W'(sum_cmd.mid_idx));
    assign eff_mid   = mid_word | pad_mid;
    assign eff_page  = ram_rdata | pad_mask(r_num_pages, page_word);
    assign page_bit  = lowest_zero(eff_page);
    assign page_new  = ram_rdata | (WORD_BITS'(1) << page_bit);
    assign mid_new   = mid_word | (WORD_BITS'(1) << r_mid_bit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_num_pages   <= MAX_PAGES;
            r_items1      <= MAX_ITEMS1;
            r_items2      <= MAX_ITEMS2;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_clr_addr    <= n_clr_addr;
            r_num_pages   <= n_num_pages;
            r_items1      <= n_items1;
            r_items2      <= n_items2;
            r_out_valid   <= n_out_valid;
        end
        r_action      <= n_action;
        r_index       <= n_index;
        r_top         <= n_top;
        r_mid_bit     <= n_mid_bit;
        r_pend_idx    <= n_pend_idx;
        r_pend_status <= n_pend_status;
        r_out_idx     <= n_out_idx;
        r_out_status  <= n_out_status;
    end

    always_comb begin
        n_state       = r_state;
        n_action      = r_action;
        n_index       = r_index;
        n_top         = r_top;
        n_mid_bit     = r_mid_bit;
        n_clr_addr    = r_clr_addr;
        n_num_pages   = r_num_pages;
        n_items1      = r_items1;
        n_items2      = r_items2;
        n_pend_idx    = r_pend_idx;
        n_pend_status = r_pend_status;
        n_out_valid   = r_out_valid && !o_res.ready;
        n_out_idx     = r_out_idx;
        n_out_status  = r_out_status;

        ram_we    = 1'b0;
        ram_waddr = page_word;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = page_word;

        sum_cmd.clear   = 1'b0;
        sum_cmd.mid_idx = (r_action == ACT_FREE) ? r_index[PAGE_W-1:PAGE_W-MW_W] : r_top;
        sum_cmd.mid_en  = 1'b0;
        sum_cmd.mid_set = 1'b0;
        sum_cmd.mid_bit = (r_action == ACT_FREE) ? r_index[PAGE_W-MW_W-1:BIT_W] : r_mid_bit;
        sum_cmd.top_en  = 1'b0;
        sum_cmd.top_set = 1'b0;

        case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + PW_W'(1);
                if (r_clr_addr == PW_W'(PAGE_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_action = t_action'(i_req.action);
                    n_index  = i_req.page_index;
                    n_state  = S_TOP;
                end
            end
            S_TOP: begin
                if (r_action == ACT_ALLOC) begin
                    if (eff_top == WORD_ONES) begin
                        n_pend_idx    = '0;
                        n_pend_status = STATUS_FULL;
                        n_state       = S_DONE;
                    end else begin
                        n_top   = top_bit[MW_W-1:0];
                        n_state = S_MID;
                    end
                end else begin
                    n_pend_idx = r_index;
                    if ({1'b0, r_index} >= r_num_pages) begin
                        n_pend_status = STATUS_RANGE;
                        n_state       = S_DONE;
                    end else begin
                        ram_re  = 1'b1;
                        n_state = S_PAGE;
                    end
                end
            end
            S_MID: begin
                if (eff_mid == WORD_ONES) begin
                    n_pend_idx    = '0;
                    n_pend_status = STATUS_FULL;
                    n_state       = S_DONE;
                end else begin
                    n_mid_bit = lowest_zero(eff_mid);
                    ram_re    = 1'b1;
                    ram_raddr = {r_top, lowest_zero(eff_mid)};
                    n_state   = S_PAGE;
                end
            end
            S_PAGE: begin
                n_state = S_DONE;
                if (r_action == ACT_ALLOC) begin
                    if (eff_page == WORD_ONES) begin
                        n_pend_idx    = '0;
                        n_pend_status = STATUS_FULL;
                    end else begin
                        ram_we        = 1'b1;
                        ram_wdata     = page_new;
                        n_pend_idx    = {page_word, page_bit};
                        n_pend_status = STATUS_OK;
                        if ((page_new | pad_mask(r_num_pages, page_word)) == WORD_ONES) begin
                            sum_cmd.mid_en  = 1'b1;
                            sum_cmd.mid_set = 1'b1;
                            if ((mid_new | pad_mid) == WORD_ONES) begin
                                sum_cmd.top_en  = 1'b1;
                                sum_cmd.top_set = 1'b1;
                            end
                        end
                    end
                end else begin
                    ram_we        = 1'b1;
                    ram_wdata     = ram_rdata & ~(WORD_BITS'(1) << r_index[BIT_W-1:0]);
                    n_pend_status = STATUS_OK;
                    if (eff_page == WORD_ONES) begin
                        sum_cmd.mid_en = 1'b1;
                        if (eff_mid == WORD_ONES) begin
                            sum_cmd.top_en = 1'b1;
                        end
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_idx    = r_pend_idx;
                    n_out_status = r_pend_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_num_pages   = cfg_sat;
            n_items1      = items1_sum[CNT_W-1:BIT_W];
            n_items2      = items2_sum[ITEMS1_W-1:BIT_W];
            n_clr_addr    = '0;
            n_state       = S_CLEAR;
            sum_cmd.clear = 1'b1;
        end
    end

endmodule

`default_nettype wire

[design/hbpa_ram.sv]
// ----------------------------------------------------------------------------
// hbpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hbpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[design/hbpa_summary.sv]
// ----------------------------------------------------------------------------
// hbpa_summary
// Middle and top fullness words; set or clear one bit per level per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hbpa_summary
    import hbpa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_sum_cmd             i_cmd,
    output logic      [WORD_BITS-1:0] o_mid_word,
    output logic      [MID_WORDS-1:0] o_top_word
);

    logic [WORD_BITS-1:0] r_mid [MID_WORDS];
    logic [MID_WORDS-1:0] r_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < MID_WORDS; i++) begin
                r_mid[i] <= '0;
            end
            r_top <= '0;
        end else begin
            if (i_cmd.mid_en) begin
                r_mid[i_cmd.mid_idx][i_cmd.mid_bit] <= i_cmd.mid_set;
            end
            if (i_cmd.top_en) begin
                r_top[i_cmd.mid_idx] <= i_cmd.top_set;
            end
        end
    end

    assign o_mid_word = r_mid[i_cmd.mid_idx];
    assign o_top_word = r_top;

endmodule

`default_nettype wire

[sim/tb_hierarchical_bitmap_page_allocator.sv]
// ----------------------------------------------------------------------------
// tb_hierarchical_bitmap_page_allocator
// Self-checking bench for the bitmap page allocator. A tracker class keeps
// its own copy of the three bitmap levels and of the page total, predicts the
// result word of every accepted request and checks each result word in
// order. Stimulus: a directed pass over the corner cases, then phases of
// fill-and-drain traffic over a range of page totals, with random
// idling on both channels outside one steady phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_hierarchical_bitmap_page_allocator
    import hbpa_pkg::*;
();

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        t_status           status;
    } t_grant;

    class bitmap_tracker;
        logic [WORD_BITS-1:0] page_words [PAGE_WORDS];
        logic [WORD_BITS-1:0] mid_words [MID_WORDS];
        logic [WORD_BITS-1:0] top_word;
        int unsigned          page_limit;
        t_grant               grants_due[$];
        int unsigned          errors;

        function new();
            page_limit = 32'(MAX_PAGES);
            errors     = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (page_words[i]) page_words[i] = '0;
            foreach (mid_words[i]) mid_words[i] = '0;
            top_word = '0;
        endfunction

        function void load_num_pages(logic [CNT_W-1:0] v);
            page_limit = 32'((v > MAX_PAGES) ? MAX_PAGES : v);
            wipe();
        endfunction

        // real entries at a level: pages, page words, middle words
        function int unsigned span(int lvl);
            int unsigned n;
            n = page_limit;
            for (int i = 0; i < lvl; i++) n = (n + WORD_BITS - 1) / WORD_BITS;
            return n;
        endfunction

        function logic [WORD_BITS-1:0] padding(int lvl, int unsigned w);
            int unsigned n;
            int unsigned base;
            n    = span(lvl);
            base = w * WORD_BITS;
            if (base >= n) return '1;
            if (n - base >= WORD_BITS) return '0;
            return ~((64'd1 << (n - base)) - 64'd1);
        endfunction

        function int unsigned first_clear(logic [WORD_BITS-1:0] v);
            int unsigned b;
            b = 0;
            while (b < WORD_BITS - 1 && v[b]) b++;
            return b;
        endfunction

        function t_grant allocate();
            t_grant               g;
            logic [WORD_BITS-1:0] eff;
            int unsigned          off;
            int unsigned          w;
            int unsigned          m;
            g.page   = '0;
            g.status = STATUS_FULL;
            eff = top_word | padding(2, 0);
            if (&eff) return g;
            off = first_clear(eff);
            eff = mid_words[off % MID_WORDS] | padding(1, off);
            if (&eff) return g;
            off = off * WORD_BITS + first_clear(eff);
            eff = page_words[off % PAGE_WORDS] | padding(0, off);
            if (&eff) return g;
            off = off * WORD_BITS + first_clear(eff);
            w = off / WORD_BITS;
            m = w / WORD_BITS;
            page_words[w % PAGE_WORDS][off % WORD_BITS] = 1'b1;
            if (&(page_words[w % PAGE_WORDS] | padding(0, w))) begin
                mid_words[m % MID_WORDS][w % WORD_BITS] = 1'b1;
                if (&(mid_words[m % MID_WORDS] | padding(1, m))) begin
                    top_word[m % WORD_BITS] = 1'b1;
                end
            end
            g.page   = PAGE_W'(off);
            g.status = STATUS_OK;
            return g;
        endfunction

        function t_grant release_page(logic [PAGE_W-1:0] pg);
            t_grant               g;
            logic [WORD_BITS-1:0] was;
            int unsigned          w;
            int unsigned          m;
            g.page   = pg;
            g.status = STATUS_OK;
            if (pg >= page_limit) begin
                g.status = STATUS_RANGE;
                return g;
            end
            w = pg / WORD_BITS;
            m = w / WORD_BITS;
            was = page_words[w] | padding(0, w);
            page_words[w][pg % WORD_BITS] = 1'b0;
            if (&was) begin
                was = mid_words[m] | padding(1, m);
                mid_words[m][w % WORD_BITS] = 1'b0;
                if (&was) top_word[m % WORD_BITS] = 1'b0;
            end
            return g;
        endfunction

        function void note_request(t_action act, logic [PAGE_W-1:0] pg);
            if (act == ACT_ALLOC) begin
                grants_due.push_back(allocate());
            end else begin
                grants_due.push_back(release_page(pg));
            end
        endfunction

        function void check_result(logic [PAGE_W-1:0] pg, logic [1:0] st);
            t_grant g;
            if (grants_due.size() == 0) begin
                $error("result word with no request pending: page_index_res %0d status %0d",
                       pg, st);
                errors++;
                return;
            end
            g = grants_due.pop_front();
            if (pg !== g.page) begin
                $error("page_index_res: expected %0d, got %0d", g.page, pg);
                errors++;
            end
            if (st !== g.status) begin
                $error("status: expected %0d, got %0d", g.status, st);
                errors++;
            end
        endfunction

        function int pending();
            return grants_due.size();
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;
    logic             steady;
    bitmap_tracker    tracker;

    hbpa_req_if req_if();
    hbpa_res_if res_if();

    hierarchical_bitmap_page_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #8000000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            res_if.ready <= steady || ($urandom_range(0, 99) >= 12);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            tracker.check_result(res_if.page_index_res, res_if.status);
        end
    end

    task automatic send_word(t_action act, logic [PAGE_W-1:0] pg);
        if (!steady && $urandom_range(0, 99) < 12) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.action     <= act;
        req_if.page_index <= pg;
        do @(posedge i_clk); while (!req_if.ready);
        tracker.note_request(act, pg);
    endtask

    // hold the sender until every result word is back
    task automatic drain();
        req_if.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_num_pages(logic [CNT_W-1:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.load_num_pages(v);
    endtask

    initial begin
        logic [CNT_W-1:0] phase_counts [14];
        logic [CNT_W-1:0] cnt;
        int unsigned      near;
        int unsigned      n;
        int unsigned      bias;

        phase_counts = '{1, 2, 63, 64, 65, 66, 127, 128, 129, 190, 4097, 65535, 65536,
                         131071};
        tracker           = new();
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        steady            = 1'b0;
        req_if.valid      = 1'b0;
        req_if.action     = ACT_ALLOC;
        req_if.page_index = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(ACT_ALLOC, 16'h0000);
        send_word(ACT_ALLOC, 16'hFFFF);
        send_word(ACT_ALLOC, 16'h1234);
        send_word(ACT_FREE, 16'h0001);
        send_word(ACT_FREE, 16'h0001);
        send_word(ACT_ALLOC, 16'h0000);
        send_word(ACT_FREE, 16'hFFFF);
        send_word(ACT_FREE, 16'h8000);
        send_word(ACT_FREE, 16'h5555);
        send_word(ACT_FREE, 16'hAAAA);
        set_num_pages(17'd0);
        send_word(ACT_ALLOC, 16'h0000);
        send_word(ACT_FREE, 16'h0000);
        set_num_pages(17'd1);
        send_word(ACT_ALLOC, 16'h0000);
        send_word(ACT_ALLOC, 16'h0000);
        send_word(ACT_FREE, 16'h0001);
        send_word(ACT_FREE, 16'h0000);
        send_word(ACT_ALLOC, 16'h0000);
        set_num_pages(17'h1FFFF);
        send_word(ACT_FREE, 16'hFFFF);
        send_word(ACT_ALLOC, 16'h0000);

        for (int p = 0; p < 15; p++) begin
            cnt = (p < 14) ? phase_counts[p] : CNT_W'($urandom_range(1, 131071));
            set_num_pages(cnt);
            steady = (p == 3);
            near   = (cnt > 256) ? 256 : cnt;
            n      = $urandom_range(120, 180);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 99) < 3) drain();
                bias = (k < n / 2) ? 75 : 35;
                if ($urandom_range(0, 99) < bias) begin
                    send_word(ACT_ALLOC, PAGE_W'($urandom));
                end else if ($urandom_range(0, 99) < 80) begin
                    send_word(ACT_FREE, PAGE_W'($urandom_range(0, near - 1)));
                end else begin
                    send_word(ACT_FREE, PAGE_W'($urandom));
                end
            end
        end
        steady = 1'b0;

        drain();
        repeat (20) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
design/hbpa_pkg.sv
design/hbpa_if.sv
design/hbpa_ram.sv
design/hbpa_summary.sv
design/hierarchical_bitmap_page_allocator.sv
sim/tb_hierarchical_bitmap_page_allocator.sv
